// ----- hw/rtl/espl_pkg.sv -----
`timescale 1ns / 1ps

package espl_pkg;

	// One input beat: encoder reading, target and the two tick flags.
	typedef struct packed {
		logic [15:0]        encoder_count;
		logic signed [15:0] target_rpm;
		logic               stop;
		logic               clear;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [15:0]        drive_value;
		logic signed [15:0] speed_rpm;
		logic               limited;
	} out_beat_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_DRIVE_LOW   = 3'd3,
		REG_DRIVE_HIGH  = 3'd4,
		REG_INT_LIMIT   = 3'd5
	} cfg_reg_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int GAIN_W     = 32;
	localparam int LIMIT_W    = 16;

	// Shared multiplier: signed operands, full-width registered product.
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// Error, integral and previous error are signed Q.9 in 28 bits.
	localparam int ERR_W  = 28;
	localparam int FRAC_W = 9;
	localparam logic signed [ERR_W-1:0] ERR_MAX = 28'sh7FF_FFFF;
	localparam logic signed [ERR_W-1:0] ERR_MIN = -28'sh800_0000;

	// 375/512 rpm per count.
	localparam logic signed [MUL_W-1:0] SPEED_SCALE = 33'sd375;

	// x/100 for 0 <= x <= 2^27 as (x * ceil(2^34/100)) >> 34, exact below 2^30.
	localparam logic signed [MUL_W-1:0] DIV100_MUL = 33'sd171798692;
	localparam int                      DIV100_SHIFT = 34;

	// Drive accumulator is signed Q.25.
	localparam int ACC_W      = 64;
	localparam int DRIVE_FRAC = 25;
	localparam logic signed [ACC_W-1:0] ACC_INIT = 64'sd1000 <<< DRIVE_FRAC;

	// Derivative product saturates to +-2^54 before the factor 100.
	localparam int D_W = 56;
	localparam logic signed [D_W-1:0] DSAT = 56'sd18014398509481984;

	// Register reset values.
	localparam logic signed [GAIN_W-1:0] GAIN_P_RST     = 32'sd3277;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST     = 32'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST     = 32'sd0;
	localparam logic [LIMIT_W-1:0]       DRIVE_LOW_RST  = 16'd1000;
	localparam logic [LIMIT_W-1:0]       DRIVE_HIGH_RST = 16'd2000;
	localparam logic [LIMIT_W-1:0]       INT_LIMIT_RST  = 16'd500;

endpackage

// ----- hw/rtl/encoder_speed_pid_loop_unit.sv -----
`timescale 1ns / 1ps
// out_valid rises as the sequencer leaves ST_LO, the last of its states after an
// input beat is accepted, later only while an earlier result is still waiting on out_ready.
// One item is in work at a time: in_ready stays low until the sequencer is idle again,
// as the single shared 33x33 multiplier and the accumulator walk the PID terms in turn.
// Reset (arst_n low) restores the register defaults and clears the count,
// integral and error history; no result is pending after reset.
module encoder_speed_pid_loop_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  espl_pkg::in_beat_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output espl_pkg::out_beat_t                out_data,
	input  logic                               cfg_we,
	input  logic [espl_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [espl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SPEED_W = COUNT_WIDTH + espl_pkg::FRAC_W;
	localparam int ER_W    = ((SPEED_W > espl_pkg::ERR_W) ? SPEED_W : espl_pkg::ERR_W) + 1;
	localparam int I_W     = espl_pkg::ERR_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SPEED, ST_ERR, ST_DIV, ST_INT, ST_P, ST_I, ST_D,
		ST_D6, ST_D5, ST_D2, ST_HI, ST_LO
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [espl_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [espl_pkg::LIMIT_W-1:0]       drive_low_q, drive_high_q, int_limit_q;

	// Loop state.
	logic [COUNT_WIDTH-1:0]              prev_count_q;
	logic signed [espl_pkg::ERR_W-1:0]   integ_q;
	logic signed [espl_pkg::ERR_W-1:0]   perr_q;

	// Per-item working registers.
	logic [COUNT_WIDTH-1:0]              now_q;
	logic signed [15:0]                  target_q;
	logic                                tpos_q;
	logic signed [SPEED_W-1:0]           spd_q;
	logic signed [espl_pkg::ERR_W-1:0]   err_q;
	logic signed [espl_pkg::ERR_W:0]     deriv_q;
	logic signed [15:0]                  rpm_q;
	logic signed [espl_pkg::ACC_W-1:0]   acc_q;
	logic signed [espl_pkg::D_W-1:0]     d_q;
	logic signed [espl_pkg::ACC_W-1:0]   v_q;

	logic signed [espl_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic signed [espl_pkg::PROD_W-1:0]  prod;

	logic [COUNT_WIDTH-1:0]              udiff;
	logic [espl_pkg::ERR_W-1:0]          err_mag;
	logic signed [SPEED_W-1:0]           spd;
	logic signed [ER_W-1:0]              tgt_w, err_raw;
	logic signed [espl_pkg::ERR_W-1:0]   err_sat;
	logic signed [SPEED_W-1:0]           rsum, rq;
	logic signed [15:0]                  rpm_sat;
	logic [espl_pkg::ERR_W-1:0]          quot;
	logic signed [I_W-1:0]               qs, isum, ilim, integ_new;
	logic signed [espl_pkg::D_W-1:0]     d_sat;
	logic signed [espl_pkg::ACC_W-1:0]   hi_lim, lo_lim, vfin, acc_add;
	logic                                accept_in, out_free;

	assign accept_in = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid || out_ready;

	espl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign udiff   = now_q - prev_count_q;
	assign err_mag = err_q[espl_pkg::ERR_W-1] ? espl_pkg::ERR_W'(-err_q)
	                                          : espl_pkg::ERR_W'(err_q);

	// Operand selection for the shared multiplier; the product is registered in
	// espl_mul and read in the state after the operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SPEED: begin
				mul_a = espl_pkg::MUL_W'($signed(udiff));
				mul_b = espl_pkg::SPEED_SCALE;
			end
			ST_DIV: begin
				mul_a = $signed({{(espl_pkg::MUL_W - espl_pkg::ERR_W){1'b0}}, err_mag});
				mul_b = espl_pkg::DIV100_MUL;
			end
			ST_INT: begin
				mul_a = espl_pkg::MUL_W'(gain_p_q);
				mul_b = espl_pkg::MUL_W'(err_q);
			end
			ST_P: begin
				mul_a = espl_pkg::MUL_W'(gain_i_q);
				mul_b = espl_pkg::MUL_W'(integ_q);
			end
			ST_I: begin
				mul_a = espl_pkg::MUL_W'(gain_d_q);
				mul_b = espl_pkg::MUL_W'(deriv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Speed and error.
	always_comb begin
		spd     = $signed(prod[SPEED_W-1:0]);
		tgt_w   = ER_W'($signed({target_q, {espl_pkg::FRAC_W{1'b0}}}));
		err_raw = tgt_w - ER_W'(spd);
		if (err_raw > ER_W'(espl_pkg::ERR_MAX)) begin
			err_sat = espl_pkg::ERR_MAX;
		end else if (err_raw < ER_W'(espl_pkg::ERR_MIN)) begin
			err_sat = espl_pkg::ERR_MIN;
		end else begin
			err_sat = err_raw[espl_pkg::ERR_W-1:0];
		end
	end

	// Speed in whole rpm, truncated toward zero and saturated to 16 bits.
	always_comb begin
		rsum = spd_q + (spd_q[SPEED_W-1] ? SPEED_W'(511) : SPEED_W'(0));
		rq   = rsum >>> espl_pkg::FRAC_W;
		if (rq > SPEED_W'(32767)) begin
			rpm_sat = 16'sh7FFF;
		end else if (rq < -$signed(SPEED_W'(32768))) begin
			rpm_sat = -16'sh8000;
		end else begin
			rpm_sat = rq[15:0];
		end
	end

	// Integral update: error/100 toward zero, then the symmetric clamp.
	always_comb begin
		quot = prod[espl_pkg::DIV100_SHIFT +: espl_pkg::ERR_W];
		qs   = err_q[espl_pkg::ERR_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		isum = I_W'(integ_q) + qs;
		ilim = $signed({4'b0, int_limit_q, {espl_pkg::FRAC_W{1'b0}}});
		if (isum > ilim) begin
			integ_new = ilim;
		end else if (isum < -ilim) begin
			integ_new = -ilim;
		end else begin
			integ_new = isum;
		end
	end

	always_comb begin
		if (prod > espl_pkg::PROD_W'(espl_pkg::DSAT)) begin
			d_sat = espl_pkg::DSAT;
		end else if (prod < espl_pkg::PROD_W'(-espl_pkg::DSAT)) begin
			d_sat = -espl_pkg::DSAT;
		end else begin
			d_sat = prod[espl_pkg::D_W-1:0];
		end
	end

	// One add per cycle into the drive accumulator; 100*d is walked as
	// d*64 + d*32 + d*4.
	always_comb begin
		case (state_q)
			ST_P, ST_I: acc_add = prod[espl_pkg::ACC_W-1:0];
			ST_D6:      acc_add = espl_pkg::ACC_W'(d_q) <<< 6;
			ST_D5:      acc_add = espl_pkg::ACC_W'(d_q) <<< 5;
			ST_D2:      acc_add = espl_pkg::ACC_W'(d_q) <<< 2;
			default:    acc_add = '0;
		endcase
	end

	assign hi_lim = $signed({23'b0, drive_high_q, {espl_pkg::DRIVE_FRAC{1'b0}}});
	assign lo_lim = $signed({23'b0, drive_low_q, {espl_pkg::DRIVE_FRAC{1'b0}}});
	assign vfin   = (v_q < lo_lim) ? lo_lim : v_q;

	// Working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					now_q    <= COUNT_WIDTH'(in_data.encoder_count);
					target_q <= in_data.stop ? 16'sd0 : in_data.target_rpm;
					tpos_q   <= !in_data.stop && !in_data.target_rpm[15]
					            && (|in_data.target_rpm);
				end
			end
			ST_ERR: begin
				spd_q <= spd;
				err_q <= err_sat;
			end
			ST_DIV: begin
				rpm_q   <= rpm_sat;
				deriv_q <= I_W'(err_q) - I_W'(perr_q);
			end
			ST_INT: acc_q <= espl_pkg::ACC_INIT;
			ST_P, ST_I, ST_D6, ST_D5, ST_D2: acc_q <= acc_q + acc_add;
			ST_D:  d_q <= d_sat;
			ST_HI: v_q <= (acc_q > hi_lim) ? hi_lim : acc_q;
			default: begin
			end
		endcase
	end

	// Sequencer, configuration, loop state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid    <= 1'b0;
			out_data     <= '0;
			gain_p_q     <= espl_pkg::GAIN_P_RST;
			gain_i_q     <= espl_pkg::GAIN_I_RST;
			gain_d_q     <= espl_pkg::GAIN_D_RST;
			drive_low_q  <= espl_pkg::DRIVE_LOW_RST;
			drive_high_q <= espl_pkg::DRIVE_HIGH_RST;
			int_limit_q  <= espl_pkg::INT_LIMIT_RST;
			prev_count_q <= '0;
			integ_q      <= '0;
			perr_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					espl_pkg::REG_GAIN_P:     gain_p_q     <= $signed(cfg_data);
					espl_pkg::REG_GAIN_I:     gain_i_q     <= $signed(cfg_data);
					espl_pkg::REG_GAIN_D:     gain_d_q     <= $signed(cfg_data);
					espl_pkg::REG_DRIVE_LOW:  drive_low_q  <= cfg_data[espl_pkg::LIMIT_W-1:0];
					espl_pkg::REG_DRIVE_HIGH: drive_high_q <= cfg_data[espl_pkg::LIMIT_W-1:0];
					espl_pkg::REG_INT_LIMIT:  int_limit_q  <= cfg_data[espl_pkg::LIMIT_W-1:0];
					default: begin
					end
				endcase
			end

			// In the last state a taken beat is replaced by the new one below.
			if (out_valid && out_ready && (state_q != ST_LO)) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						// Clear makes this tick's count difference zero.
						if (in_data.clear) begin
							prev_count_q <= COUNT_WIDTH'(in_data.encoder_count);
							integ_q      <= '0;
							perr_q       <= '0;
						end
						state_q <= ST_SPEED;
					end
				end
				ST_SPEED: begin
					prev_count_q <= now_q;
					state_q      <= ST_ERR;
				end
				ST_ERR: state_q <= ST_DIV;
				ST_DIV: begin
					perr_q  <= err_q;
					state_q <= ST_INT;
				end
				ST_INT: begin
					integ_q <= integ_new[espl_pkg::ERR_W-1:0];
					state_q <= ST_P;
				end
				ST_P:  state_q <= ST_I;
				ST_I:  state_q <= ST_D;
				ST_D:  state_q <= ST_D6;
				ST_D6: state_q <= ST_D5;
				ST_D5: state_q <= ST_D2;
				ST_D2: state_q <= ST_HI;
				ST_HI: state_q <= ST_LO;
				ST_LO: begin
					if (out_free) begin
						out_valid          <= 1'b1;
						out_data.speed_rpm <= rpm_q;
						if (tpos_q) begin
							out_data.drive_value <= vfin[espl_pkg::DRIVE_FRAC +: 16];
							out_data.limited     <= (vfin != acc_q);
						end else begin
							// A target of zero or less holds the motor at the
							// lower limit and empties the integral.
							out_data.drive_value <= drive_low_q;
							out_data.limited     <= 1'b1;
							integ_q              <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/espl_mul.sv -----
`timescale 1ns / 1ps

module espl_mul (
	input  logic                                 clk,
	input  logic signed [espl_pkg::MUL_W-1:0]    a,
	input  logic signed [espl_pkg::MUL_W-1:0]    b,
	output logic signed [espl_pkg::PROD_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- hw/rtl/espl_chk.sv -----
`timescale 1ns / 1ps

module espl_chk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  espl_pkg::out_beat_t  out_data
);

	// A result beat that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// One item at a time: the block is busy after a beat is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input accepted while an item is in work");

	// A new result only appears at the end of a busy period.
	a_rise_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

	// Accepting an input never touches the result register in the next cycle.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> $stable(out_data))
		else $error("result changed right after an input beat");

endmodule

bind encoder_speed_pid_loop_unit espl_chk u_espl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
